[rtl/core/eaq_pkg.sv]
// ----------------------------------------------------------------------------
// eaq_pkg: shared types and constants of the Euler angle converter
// Holds the arctangent table and the CORDIC gain that the rotator uses, and the
// saturation limit that the rotator and the top level both use.
// ----------------------------------------------------------------------------
package eaq_pkg;

	localparam int unsigned DEF_CORDIC_STEPS = 16;
	localparam int unsigned DEF_ANGLE_BITS   = 16;
	localparam int unsigned ATAN_ENTRIES     = 24;
	localparam int unsigned QW               = 18;
	localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
	localparam logic signed [QW-1:0] ONE_Q16 = 18'sd65536;

	typedef logic signed [QW-1:0] q16_t;

	typedef logic [31:0] atan_tab_t [ATAN_ENTRIES];
	localparam atan_tab_t ATAN_TURNS = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Clamps a wide signed value to plus or minus one in Q1.16.
	function automatic q16_t sat_one(input logic signed [47:0] v);
		if (v > 48'sd65536) begin
			return ONE_Q16;
		end else if (v < -48'sd65536) begin
			return -ONE_Q16;
		end
		return v[QW-1:0];
	endfunction

endpackage

[rtl/core/eaq_cordic.sv]
// ----------------------------------------------------------------------------
// eaq_cordic: pipelined CORDIC rotator for one half-angle
// One CORDIC iteration per register stage; gives cos and sin in Q1.16.
// The pipeline holds an input register, the iteration registers and an output register, and advances on en.
// ----------------------------------------------------------------------------
module eaq_cordic #(
	parameter int unsigned CORDIC_STEPS = eaq_pkg::DEF_CORDIC_STEPS,
	parameter int unsigned ANGLE_BITS   = eaq_pkg::DEF_ANGLE_BITS
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [15:0]           angle,
	output eaq_pkg::q16_t         cos_q,
	output eaq_pkg::q16_t         sin_q
);

	localparam int unsigned N = (CORDIC_STEPS > eaq_pkg::ATAN_ENTRIES) ?
		eaq_pkg::ATAN_ENTRIES : CORDIC_STEPS;

	logic signed [33:0] x_s [N+1];
	logic signed [33:0] y_s [N+1];
	logic signed [32:0] z_s [N+1];
	logic               flip_s [N+1];

	logic signed [31:0] a_ext;
	logic [31:0]        ph;
	logic               flip;
	logic [31:0]        ph_r;

	always_comb begin
		a_ext = 32'(signed'(angle));
		ph    = 32'(a_ext[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
		flip  = ph[31] ^ ph[30];
		ph_r  = flip ? (ph - 32'h80000000) : ph;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= eaq_pkg::GAIN_Q30;
			y_s[0]    <= '0;
			z_s[0]    <= 33'(signed'(ph_r));
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		logic signed [33:0] dx, dy;
		logic signed [32:0] at;
		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;
		assign at = 33'(eaq_pkg::ATAN_TURNS[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][32]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	logic signed [33:0] xf, yf;
	assign xf = flip_s[N] ? -x_s[N] : x_s[N];
	assign yf = flip_s[N] ? -y_s[N] : y_s[N];

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= eaq_pkg::sat_one(48'((xf + 34'sd8192) >>> 14));
			sin_q <= eaq_pkg::sat_one(48'((yf + 34'sd8192) >>> 14));
		end
	end

endmodule

[rtl/core/euler_angles_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion: Z-Y-X Euler angles to a unit quaternion
//
// Channel  Direction  Payload (lowest bit first)
// s_axis   in         angle_x[15:0], angle_y[15:0], angle_z[15:0]
// m_axis   out        quat_w, quat_x, quat_y, quat_z, 18 bits each
//
// One item may enter every cycle unless the output stalls. The CORDIC
// rotators take CORDIC_STEPS + 2 stages (steps capped at ATAN_ENTRIES), then
// two stages each for Qz*Qy and (Qz*Qy)*Qx (multiply, then sum and round).
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall freezes every stage and loses nothing.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion #(
	parameter int unsigned CORDIC_STEPS = eaq_pkg::DEF_CORDIC_STEPS,
	parameter int unsigned ANGLE_BITS   = eaq_pkg::DEF_ANGLE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// angle_x [15:0], angle_y [31:16], angle_z [47:32]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// quat_w [17:0], quat_x [35:18], quat_y [53:36], quat_z [71:54]
	output logic [71:0] m_axis_tdata
);

	localparam int unsigned N = (CORDIC_STEPS > eaq_pkg::ATAN_ENTRIES) ?
		eaq_pkg::ATAN_ENTRIES : CORDIC_STEPS;
	localparam int unsigned LAT = N + 6;

	typedef eaq_pkg::q16_t quat_t [4];
	typedef logic signed [35:0] prod_t [16];

	logic            en;
	logic [LAT-1:0]  vld_q;

	// The pipeline moves when its last stage is empty or being taken.
	assign en            = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	eaq_pkg::q16_t cx, sx, cy, sy, cz, sz;

	eaq_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cx (
		.clk(clk), .en(en), .angle(s_axis_tdata[15:0]), .cos_q(cx), .sin_q(sx));
	eaq_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cy (
		.clk(clk), .en(en), .angle(s_axis_tdata[31:16]), .cos_q(cy), .sin_q(sy));
	eaq_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cz (
		.clk(clk), .en(en), .angle(s_axis_tdata[47:32]), .cos_q(cz), .sin_q(sz));

	// Qz*Qy, with Qz = (cz,0,0,sz) and Qy = (cy,0,sy,0), is sparse; the full
	// product form is kept so both stages share one layout.
	quat_t qa, qb, qx_d1, qx_d2, mid_s2;
	assign qa = '{cz, 18'sd0, 18'sd0, sz};
	assign qb = '{cy, 18'sd0, sy, 18'sd0};

	prod_t p1_s1, p2_s3;

	function automatic prod_t mul_all(input quat_t a, input quat_t b);
		prod_t p;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p[i*4+j] = 36'(a[i]) * 36'(b[j]);
			end
		end
		return p;
	endfunction

	// Hamilton sums, rounded to Q16 and saturated.
	function automatic quat_t ham_sum(input prod_t p);
		logic signed [39:0] s [4];
		quat_t r;
		s[0] = 40'(p[0])  - 40'(p[5])  - 40'(p[10]) - 40'(p[15]);
		s[1] = 40'(p[1])  + 40'(p[4])  + 40'(p[11]) - 40'(p[14]);
		s[2] = 40'(p[2])  - 40'(p[7])  + 40'(p[8])  + 40'(p[13]);
		s[3] = 40'(p[3])  + 40'(p[6])  - 40'(p[9])  + 40'(p[12]);
		for (int k = 0; k < 4; k++) begin
			r[k] = eaq_pkg::sat_one(48'((s[k] + 40'sd32768) >>> 16));
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1  <= mul_all(qa, qb);
			qx_d1  <= '{cx, sx, 18'sd0, 18'sd0};
			mid_s2 <= ham_sum(p1_s1);
			qx_d2  <= qx_d1;
			p2_s3  <= mul_all(mid_s2, qx_d2);
		end
	end

	quat_t res_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= ham_sum(p2_s3);
		end
	end

	assign m_axis_tdata = {res_s4[3], res_s4[2], res_s4[1], res_s4[0]};

`ifndef SYNTH
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output stage");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
		else $error("pipeline moved during a stall");
	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[17:0]) <= 18'sd65536 &&
		$signed(m_axis_tdata[17:0]) >= -18'sd65536))
		else $error("quat_w out of range");
`endif

endmodule

[verif/euler_angles_to_quaternion_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion_checker: result checker for the Euler converter
// Watches both stream channels, works out the quaternion for each accepted
// item with its own CORDIC and Hamilton product, and compares the results in
// order.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion_checker #(
	parameter int unsigned CORDIC_STEPS = 16,
	parameter int unsigned ANGLE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,
	output int          fail_count,
	output int          pending
);

	typedef logic signed [17:0] comp_t;
	typedef comp_t quat_t [4];
	typedef logic [71:0] quat_word_t;

	quat_word_t quat_queue [$];
	int mismatches;

	function automatic longint clamp_one(input longint v);
		if (v > 65536) begin
			return 65536;
		end else if (v < -65536) begin
			return -65536;
		end
		return v;
	endfunction

	// Half-angle cos and sin of one input angle, in Q1.16.
	function automatic void axis_cos_sin(input logic [15:0] angle, output longint c,
			output longint s);
		logic [31:0] phase;
		logic [31:0] p;
		longint x, y, z, dx, dy;
		logic flip;
		int n;
		p = 32'(signed'(angle)) & ((32'd1 << ANGLE_BITS) - 1);
		phase = p << (32 - ANGLE_BITS);
		flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
		if (flip) begin
			phase = phase - 32'h80000000;
		end
		z = longint'(signed'(phase));
		x = 652032874;
		y = 0;
		n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
		for (int i = 0; i < n; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(eaq_pkg::ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(eaq_pkg::ATAN_TURNS[i]);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = clamp_one((x + 8192) >>> 14);
		s = clamp_one((y + 8192) >>> 14);
	endfunction

	function automatic longint round_prod(input longint v);
		return clamp_one((v + 32768) >>> 16);
	endfunction

	function automatic void hamilton_mul(input longint a [4], input longint b [4],
			output longint r [4]);
		r[0] = round_prod(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
		r[1] = round_prod(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
		r[2] = round_prod(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
		r[3] = round_prod(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
	endfunction

	function automatic quat_word_t euler_to_quat(input logic [47:0] angles);
		longint qx [4], qy [4], qz [4], mid [4], res [4];
		quat_word_t word;
		qx = '{0, 0, 0, 0};
		qy = '{0, 0, 0, 0};
		qz = '{0, 0, 0, 0};
		axis_cos_sin(angles[15:0], qx[0], qx[1]);
		axis_cos_sin(angles[31:16], qy[0], qy[2]);
		axis_cos_sin(angles[47:32], qz[0], qz[3]);
		hamilton_mul(qz, qy, mid);
		hamilton_mul(mid, qx, res);
		for (int k = 0; k < 4; k++) begin
			word[k*18 +: 18] = 18'(res[k]);
		end
		return word;
	endfunction

	assign pending = quat_queue.size();

	always @(posedge clk) begin
		quat_word_t want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			quat_queue.push_back(euler_to_quat(s_axis_tdata));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (quat_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result %h", m_axis_tdata);
				end
			end else begin
				want = quat_queue.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (m_axis_tdata[k*18 +: 18] !== want[k*18 +: 18]) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("component %0d: expected %0d, got %0d", k,
								signed'(want[k*18 +: 18]),
								signed'(m_axis_tdata[k*18 +: 18]));
						end
					end
				end
			end
		end
	end

	initial mismatches = 0;

	// Leftover expectations show up in pending, which the top checks at the end.
	assign fail_count = mismatches;

endmodule

[verif/euler_angles_to_quaternion_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion_tb: stimulus and verdict for the Euler converter
// Drives directed corner angles and then random ones with random gaps on
// both channels, including a long output stall and a full drain, while the
// checker compares every result.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion_tb;

	localparam int LATENCY   = 16 + 6;
	localparam int N_RANDOM  = 1650;
	localparam int WATCHDOG  = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	logic        long_hold;
	logic        stim_done;

	euler_angles_to_quaternion dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	euler_angles_to_quaternion_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(8, 40);
		end
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	function automatic logic [15:0] random_angle();
		case ($urandom_range(0, 5))
			0: begin
				// Near a quadrant boundary; the range reduction switches at 0x4000 and 0xC000.
				return 16'($urandom_range(0, 3) * 32'h4000 + $urandom_range(0, 4)) - 16'd2;
			end
			1: begin
				return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
			end
			default: begin
				return 16'($urandom());
			end
		endcase
	endfunction

	// Offers one item and holds it until the block takes it.
	task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] az);
		s_axis_tdata  <= {az, ay, ax};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_gap();
		int n;
		n = gap_length();
		if ($urandom_range(0, 3) == 0) begin
			n = 0;
		end
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off when asked.
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (200) @(negedge clk);
				long_hold = 1'b0;
			end
			n = ($urandom_range(0, 1) == 0) ? 0 : gap_length();
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if (!arst_n || (stim_done && pending == 0)) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("euler_angles_to_quaternion_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] corners [8];
		corners = '{16'h0000, 16'h0001, 16'h4000, 16'h7FFF, 16'h8000, 16'hC000,
			16'hFFFF, 16'h2000};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		long_hold     = 1'b0;
		stim_done     = 1'b0;
		idle_cycles   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: corner angles on each axis, all axes together.
		for (int i = 0; i < 8; i++) begin
			send_angles(corners[i], 16'h0000, 16'h0000);
			send_angles(16'h0000, corners[i], 16'h0000);
			send_angles(16'h0000, 16'h0000, corners[i]);
		end
		send_angles(16'h7FFF, 16'h8000, 16'h7FFF);

		// Random, with a long output stall early on and a drain half-way.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 100) begin
				long_hold = 1'b1;
			end
			if (i == N_RANDOM / 2) begin
				s_axis_tvalid <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			send_angles(random_angle(), random_angle(), random_angle());
			send_gap();
		end
		s_axis_tvalid <= 1'b0;
		stim_done = 1'b1;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("euler_angles_to_quaternion_tb: done, clean");
		end else begin
			$display("euler_angles_to_quaternion_tb: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/eaq_pkg.sv
rtl/core/eaq_cordic.sv
rtl/core/euler_angles_to_quaternion.sv
verif/euler_angles_to_quaternion_checker.sv
verif/euler_angles_to_quaternion_tb.sv
